// ----- hw/rtl/cep_pkg.sv -----
// shared types and constants for the command entry address patcher
`timescale 1ns / 1ps
`default_nettype none

package cep_pkg;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;
	localparam int WORD_W = 64;
	localparam int ID_W   = 16;

	typedef enum logic [1:0] {
		KIND_OTHER    = 2'd0,
		KIND_CONV     = 2'd1,
		KIND_REFORMAT = 2'd2,
		KIND_PERCHAN  = 2'd3
	} task_kind_t;

	typedef enum logic [2:0] {
		CFG_WEIGHT_BASE     = 3'd0,
		CFG_ACTIVATION_BASE = 3'd1,
		CFG_INPUT_BASE      = 3'd2,
		CFG_OUTPUT_BASE     = 3'd3,
		CFG_CONV_OUT_ADDR   = 3'd4,
		CFG_COMMAND_BASE    = 3'd5,
		CFG_ZERO_POINT      = 3'd6,
		CFG_UNUSED          = 3'd7
	} cfg_index_t;

	typedef struct packed {
		logic [31:0]        weight_base;
		logic [31:0]        activation_base;
		logic [31:0]        input_base;
		logic [31:0]        output_base;
		logic [31:0]        conv_out_address;
		logic [31:0]        command_base;
		logic signed [15:0] input_zero_point;
	} cfg_t;

	localparam logic [ID_W-1:0] REG_ACT_SRC     = 16'h1070;
	localparam logic [ID_W-1:0] REG_WEIGHT_SRC  = 16'h1110;
	localparam logic [ID_W-1:0] REG_DST         = 16'h4020;
	localparam logic [ID_W-1:0] REG_ELT_DST     = 16'h5018;
	localparam logic [ID_W-1:0] REG_BIAS_SRC    = 16'h5020;
	localparam logic [ID_W-1:0] REG_CMD_ADDR    = 16'h0010;
	localparam logic [ID_W-1:0] REG_PC2_SRC     = 16'h6070;
	localparam logic [ID_W-1:0] REG_PC3_SRC     = 16'h701c;
	localparam logic [ID_W-1:0] REG_ACT_AUX_A   = 16'h4110;
	localparam logic [ID_W-1:0] REG_ACT_AUX_B   = 16'h5038;
	localparam logic [ID_W-1:0] REG_CVT_CON0    = 16'h104c;
	localparam logic [ID_W-1:0] REG_CVT_CON1    = 16'h1050;
	localparam logic [ID_W-1:0] REG_CVT_CON2    = 16'h1054;
	localparam logic [ID_W-1:0] REG_CVT_CON3    = 16'h1058;
	localparam logic [ID_W-1:0] REG_CVT_CON5    = 16'h1180;

	localparam logic [31:0] CVT_CON0_VALUE = 32'h000e38e0;
	localparam logic [15:0] CVT_GAIN       = 16'h4000;
	localparam logic [31:0] CVT_CON5_VALUE = 32'h00000fff;

endpackage

`default_nettype wire

// ----- hw/rtl/command_entry_address_patcher.sv -----
// top level: input register, rewrite logic and result register
//
// usage:
//   request channel: in_valid / in_ready with entry_word, task_kind,
//   task_weight_offset, task_bias_offset, pc2_offset, pc3_offset
//   result channel: out_valid / out_ready with patched_word, was_changed
//   apb port sets the buffer bases and input zero point; pready always high,
//   write only while no request is in flight
//   a request is registered at acceptance; the rewrite runs from that input
//   register into the result register, which holds the result until it is
//   taken, one result per request
//   throughput is one request per cycle while out_ready is set: both registers
//   load every cycle, with only the decode and one 32-bit adder between them
//   when the receiver stalls, the result register holds and the input
//   register fills; with both full, in_ready drops until out_ready returns
//   reset clears both valid flags and all configuration registers to zero
`timescale 1ns / 1ps
`default_nettype none

module command_entry_address_patcher (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [cep_pkg::ADDR_W-1:0] paddr,
	input  wire logic [cep_pkg::DATA_W-1:0] pwdata,
	output logic [cep_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [63:0]                entry_word,
	input  wire logic [1:0]                 task_kind,
	input  wire logic [31:0]                task_weight_offset,
	input  wire logic [31:0]                task_bias_offset,
	input  wire logic [31:0]                pc2_offset,
	input  wire logic [31:0]                pc3_offset,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [63:0]                     patched_word,
	output logic                            was_changed
);
	import cep_pkg::*;

	cfg_t        cfg;
	logic        valid_s1;
	logic [63:0] entry_word_s1;
	task_kind_t  task_kind_s1;
	logic [31:0] weight_off_s1;
	logic [31:0] bias_off_s1;
	logic [31:0] pc2_off_s1;
	logic [31:0] pc3_off_s1;
	logic        valid_s2;
	logic [63:0] patched_word_s2;
	logic        was_changed_s2;
	logic [63:0] patched_word_c;
	logic        was_changed_c;
	logic        load_s2;
	logic        load_s1;

	cep_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cep_patch u_patch (
		.cfg                (cfg),
		.entry_word         (entry_word_s1),
		.task_kind          (task_kind_s1),
		.task_weight_offset (weight_off_s1),
		.task_bias_offset   (bias_off_s1),
		.pc2_offset         (pc2_off_s1),
		.pc3_offset         (pc3_off_s1),
		.patched_word       (patched_word_c),
		.was_changed        (was_changed_c)
	);

	assign load_s2  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || load_s2;
	assign load_s1  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			entry_word_s1 <= entry_word;
			task_kind_s1  <= task_kind_t'(task_kind);
			weight_off_s1 <= task_weight_offset;
			bias_off_s1   <= task_bias_offset;
			pc2_off_s1    <= pc2_offset;
			pc3_off_s1    <= pc3_offset;
		end
		if (load_s2 && valid_s1) begin
			patched_word_s2 <= patched_word_c;
			was_changed_s2  <= was_changed_c;
		end
	end

	assign out_valid    = valid_s2;
	assign patched_word = patched_word_s2;
	assign was_changed  = was_changed_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/cep_regs.sv -----
// apb configuration registers holding the buffer bases and zero point
`timescale 1ns / 1ps
`default_nettype none

module cep_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [cep_pkg::ADDR_W-1:0] paddr,
	input  wire logic [cep_pkg::DATA_W-1:0] pwdata,
	output logic [cep_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	output cep_pkg::cfg_t                   cfg
);
	import cep_pkg::*;

	cfg_t       cfg_q;
	cfg_index_t idx;
	logic       wr_en;

	assign idx    = cfg_index_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				CFG_WEIGHT_BASE:     cfg_q.weight_base      <= pwdata;
				CFG_ACTIVATION_BASE: cfg_q.activation_base  <= pwdata;
				CFG_INPUT_BASE:      cfg_q.input_base       <= pwdata;
				CFG_OUTPUT_BASE:     cfg_q.output_base      <= pwdata;
				CFG_CONV_OUT_ADDR:   cfg_q.conv_out_address <= pwdata;
				CFG_COMMAND_BASE:    cfg_q.command_base     <= pwdata;
				CFG_ZERO_POINT:      cfg_q.input_zero_point <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			CFG_WEIGHT_BASE:     prdata = cfg_q.weight_base;
			CFG_ACTIVATION_BASE: prdata = cfg_q.activation_base;
			CFG_INPUT_BASE:      prdata = cfg_q.input_base;
			CFG_OUTPUT_BASE:     prdata = cfg_q.output_base;
			CFG_CONV_OUT_ADDR:   prdata = cfg_q.conv_out_address;
			CFG_COMMAND_BASE:    prdata = cfg_q.command_base;
			CFG_ZERO_POINT:      prdata = {16'h0000, cfg_q.input_zero_point};
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/cep_patch.sv -----
// rewrite rules: decode register id and task kind, one 32-bit add
`timescale 1ns / 1ps
`default_nettype none

module cep_patch (
	input  wire cep_pkg::cfg_t              cfg,
	input  wire logic [cep_pkg::WORD_W-1:0] entry_word,
	input  wire cep_pkg::task_kind_t        task_kind,
	input  wire logic [31:0]                task_weight_offset,
	input  wire logic [31:0]                task_bias_offset,
	input  wire logic [31:0]                pc2_offset,
	input  wire logic [31:0]                pc3_offset,
	output logic [cep_pkg::WORD_W-1:0]      patched_word,
	output logic                            was_changed
);
	import cep_pkg::*;

	logic [ID_W-1:0] reg_id;
	logic [31:0]     val;
	logic [31:0]     base;
	logic [31:0]     addend;
	logic [31:0]     fixed;
	logic [31:0]     sum;
	logic [31:0]     nv;
	logic            use_sum;
	logic            use_fixed;
	logic            nz;
	logic            conv;
	logic            reformat;
	logic            perchan;

	assign reg_id   = entry_word[15:0];
	assign val      = entry_word[47:16];
	assign nz       = (val != 32'd0);
	assign conv     = (task_kind == KIND_CONV);
	assign reformat = (task_kind == KIND_REFORMAT);
	assign perchan  = (task_kind == KIND_PERCHAN);

	always_comb begin
		base      = cfg.activation_base;
		addend    = val;
		fixed     = val;
		use_sum   = 1'b0;
		use_fixed = 1'b0;
		case (reg_id)
			REG_ACT_SRC: begin
				if (nz) begin
					use_sum = 1'b1;
				end else if (conv) begin
					use_fixed = 1'b1;
					fixed     = cfg.input_base;
				end
			end
			REG_WEIGHT_SRC: begin
				use_sum = 1'b1;
				base    = cfg.weight_base;
				addend  = nz ? val : task_weight_offset;
			end
			REG_DST: begin
				if (reformat) begin
					use_sum = 1'b1;
					base    = cfg.output_base;
				end else if (!nz) begin
					use_fixed = 1'b1;
					fixed     = cfg.conv_out_address;
				end else begin
					use_sum = 1'b1;
				end
			end
			REG_ELT_DST: begin
				if (nz) begin
					use_sum = 1'b1;
					base    = reformat ? cfg.conv_out_address : cfg.activation_base;
				end else if (!conv) begin
					use_fixed = 1'b1;
					fixed     = cfg.conv_out_address;
				end
			end
			REG_BIAS_SRC: begin
				base = cfg.weight_base;
				if (nz) begin
					use_sum = 1'b1;
				end else if (conv) begin
					use_sum = 1'b1;
					addend  = task_bias_offset;
				end
			end
			REG_CMD_ADDR: begin
				base    = cfg.command_base;
				use_sum = nz;
			end
			REG_PC2_SRC: begin
				base = cfg.weight_base;
				if (nz) begin
					use_sum = 1'b1;
				end else if (perchan && (pc2_offset != 32'd0)) begin
					use_sum = 1'b1;
					addend  = pc2_offset;
				end
			end
			REG_PC3_SRC: begin
				base = cfg.weight_base;
				if (nz) begin
					use_sum = 1'b1;
				end else if (perchan && (pc3_offset != 32'd0)) begin
					use_sum = 1'b1;
					addend  = pc3_offset;
				end
			end
			REG_ACT_AUX_A, REG_ACT_AUX_B: begin
				use_sum = nz;
			end
			REG_CVT_CON0: begin
				use_fixed = conv;
				fixed     = CVT_CON0_VALUE;
			end
			REG_CVT_CON1, REG_CVT_CON2, REG_CVT_CON3: begin
				use_fixed = conv;
				fixed     = {CVT_GAIN, cfg.input_zero_point};
			end
			REG_CVT_CON5: begin
				use_fixed = conv;
				fixed     = CVT_CON5_VALUE;
			end
			default: begin
			end
		endcase
	end

	assign sum = base + addend;

	always_comb begin
		if (use_sum) begin
			nv = sum;
		end else if (use_fixed) begin
			nv = fixed;
		end else begin
			nv = val;
		end
	end

	assign patched_word = {entry_word[63:48], nv, entry_word[15:0]};
	assign was_changed  = (nv != val);

endmodule

`default_nettype wire
